// ===== hw/rtl/jptl_pkg.sv =====
package jptl_pkg;

  localparam int JOINT_W    = 3;
  localparam int ANGLE_W    = 32;
  localparam int GAIN_W     = 20;
  localparam int TORQUE_W   = 24;
  localparam int INTEG_W    = 48;
  localparam int TS_W       = 24;
  localparam int ELIM_W     = 29;
  localparam int TLIM_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;

  localparam int NUM_JOINTS_DEF   = 7;
  localparam int LARGE_JOINTS_DEF = 4;

  localparam logic [TS_W-1:0]   TS_RST         = TS_W'(16777);
  localparam logic [ELIM_W-1:0] ELIM_RST       = ELIM_W'(4685083);
  localparam logic [TLIM_W-1:0] TLIM_LARGE_RST = TLIM_W'(2949120);
  localparam logic [TLIM_W-1:0] TLIM_SMALL_RST = TLIM_W'(1474560);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP          = 2'd0,
    REG_ERROR_LIMIT        = 2'd1,
    REG_TORQUE_LIMIT_LARGE = 2'd2,
    REG_TORQUE_LIMIT_SMALL = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/jptl_integ_store.sv =====
module jptl_integ_store #(
  parameter int DEPTH = jptl_pkg::NUM_JOINTS_DEF,
  parameter int AW    = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [jptl_pkg::INTEG_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [jptl_pkg::INTEG_W-1:0]  wr_data
);
  import jptl_pkg::*;

  logic [INTEG_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [INTEG_W-1:0] rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/joint_pi_torque_loop.sv =====
// Accepts one input word at a time; in_stall stays high until its result is loaded.
// The sequencer walks each word through the integral memory read, error clamp, two
// multiply steps, the integral write-back, the torque sum and the torque limit clamp.
// A full output register holds the last step until the word is taken.
// Reset: configuration registers take their defaults, all joint integrals read as zero.
module joint_pi_torque_loop #(
  parameter int NUM_JOINTS   = jptl_pkg::NUM_JOINTS_DEF,
  parameter int LARGE_JOINTS = jptl_pkg::LARGE_JOINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [jptl_pkg::JOINT_W-1:0]          in_joint,
  input  logic signed [jptl_pkg::ANGLE_W-1:0]   in_position,
  input  logic signed [jptl_pkg::ANGLE_W-1:0]   in_target,
  input  logic [jptl_pkg::GAIN_W-1:0]           in_stiffness_gain,
  input  logic [jptl_pkg::GAIN_W-1:0]           in_integral_gain,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [jptl_pkg::JOINT_W-1:0]          out_joint_out,
  output logic signed [jptl_pkg::TORQUE_W-1:0]  out_torque,
  output logic                                  out_clamped,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jptl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jptl_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import jptl_pkg::*;

  localparam int AW    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int PTS_W = ELIM_W + TS_W;
  localparam int PKP_W = ELIM_W + GAIN_W;
  localparam int HALF  = INTEG_W / 2;
  localparam int PG_W  = GAIN_W + HALF;
  localparam int R_W   = INTEG_W + 1;
  localparam int U_W   = INTEG_W + 2;
  localparam int P_W   = ELIM_W + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ERR   = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_INTEG = 9'b000001000,
    S_MAG   = 9'b000010000,
    S_MUL2  = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_TORQ  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TS_W-1:0]   ts_r;
  logic [ELIM_W-1:0] elim_r;
  logic [TLIM_W-1:0] tlim_large_r;
  logic [TLIM_W-1:0] tlim_small_r;

  logic                      in_acc;
  logic                      in_ok;
  logic [JOINT_W-1:0]        joint_r;
  logic [AW-1:0]             addr_r;
  logic                      ok_r;
  logic signed [ANGLE_W-1:0] pos_r;
  logic signed [ANGLE_W-1:0] tgt_r;
  logic [GAIN_W-1:0]         kp_r;
  logic [GAIN_W-1:0]         ki_r;

  logic signed [ANGLE_W:0]   diff_nxt;
  logic [ANGLE_W:0]          dabs_nxt;
  logic [ELIM_W-1:0]         emag_nxt;
  logic [ELIM_W-1:0]         emag_r;
  logic                      eneg_r;

  logic [PTS_W-1:0]          prod_ts_r;
  logic [PKP_W-1:0]          prod_kp_r;

  logic [INTEG_W-1:0]        integ_old;
  logic signed [INTEG_W:0]   inc_nxt;
  logic signed [INTEG_W:0]   isum_nxt;
  logic [INTEG_W-1:0]        integ_nxt;
  logic [INTEG_W-1:0]        integ_r;
  logic [INTEG_W-1:0]        imag_r;
  logic                      ineg_r;

  logic [PG_W-1:0]           ghi_r;
  logic [PG_W-1:0]           glo_r;
  logic [R_W-1:0]            r_r;
  logic signed [P_W-1:0]     p_r;
  logic signed [U_W-1:0]     u_r;
  logic signed [U_W-1:0]     u_nxt;

  logic [TLIM_W-1:0]         lim;
  logic signed [U_W-1:0]     lim_s;
  logic signed [U_W-1:0]     torque_sel;
  logic                      clamped_nxt;
  logic                      out_load;

  logic                      out_valid_r;
  logic [JOINT_W-1:0]        out_joint_r;
  logic [TORQUE_W-1:0]       out_torque_r;
  logic                      out_clamped_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r         <= TS_RST;
      elim_r       <= ELIM_RST;
      tlim_large_r <= TLIM_LARGE_RST;
      tlim_small_r <= TLIM_SMALL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIME_STEP:          ts_r         <= cfg_data[TS_W-1:0];
        REG_ERROR_LIMIT:        elim_r       <= cfg_data[ELIM_W-1:0];
        REG_TORQUE_LIMIT_LARGE: tlim_large_r <= cfg_data[TLIM_W-1:0];
        REG_TORQUE_LIMIT_SMALL: tlim_small_r <= cfg_data[TLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_ok    = int'(in_joint) < NUM_JOINTS;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_ERR;
      S_ERR:   state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_INTEG;
      S_INTEG: state_nxt = S_MAG;
      S_MAG:   state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_TORQ;
      S_TORQ:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  jptl_integ_store #(
    .DEPTH (NUM_JOINTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && in_ok),
    .rd_addr (AW'(in_joint)),
    .rd_data (integ_old),
    .wr_en   ((state_r == S_INTEG) && ok_r),
    .wr_addr (addr_r),
    .wr_data (integ_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      joint_r <= in_joint;
      addr_r  <= AW'(in_joint);
      ok_r    <= in_ok;
      pos_r   <= in_position;
      tgt_r   <= in_target;
      kp_r    <= in_stiffness_gain;
      ki_r    <= in_integral_gain;
    end
  end

  // clamp error magnitude, keep sign apart
  always_comb begin
    diff_nxt = {tgt_r[ANGLE_W-1], tgt_r} - {pos_r[ANGLE_W-1], pos_r};
    dabs_nxt = diff_nxt[ANGLE_W] ? (ANGLE_W+1)'(-diff_nxt) : (ANGLE_W+1)'(diff_nxt);
    emag_nxt = (dabs_nxt > (ANGLE_W+1)'(elim_r)) ? elim_r : dabs_nxt[ELIM_W-1:0];
  end

  // add signed increment, saturate to 48 bits
  always_comb begin
    inc_nxt  = $signed((INTEG_W+1)'(prod_ts_r[PTS_W-1:TS_W]));
    if (eneg_r) begin
      inc_nxt = -inc_nxt;
    end
    isum_nxt = $signed({integ_old[INTEG_W-1], integ_old}) + inc_nxt;
    if (isum_nxt[INTEG_W] != isum_nxt[INTEG_W-1]) begin
      integ_nxt = isum_nxt[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = isum_nxt[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (!ok_r) begin
      u_nxt = '0;
    end else if (ineg_r) begin
      u_nxt = U_W'(p_r) - $signed(U_W'(r_r));
    end else begin
      u_nxt = U_W'(p_r) + $signed(U_W'(r_r));
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_ERR: begin
        emag_r <= emag_nxt;
        eneg_r <= diff_nxt[ANGLE_W];
      end
      S_MUL1: begin
        prod_ts_r <= PTS_W'(emag_r) * PTS_W'(ts_r);
        prod_kp_r <= PKP_W'(emag_r) * PKP_W'(kp_r);
      end
      S_INTEG: begin
        integ_r <= integ_nxt;
      end
      S_MAG: begin
        imag_r <= integ_r[INTEG_W-1] ? -integ_r : integ_r;
        ineg_r <= integ_r[INTEG_W-1];
      end
      S_MUL2: begin
        ghi_r <= PG_W'(ki_r) * PG_W'(imag_r[INTEG_W-1:HALF]);
        glo_r <= PG_W'(ki_r) * PG_W'(imag_r[HALF-1:0]);
      end
      S_SUM: begin
        r_r <= R_W'({ghi_r, 4'b0000}) + R_W'(glo_r[PG_W-1:GAIN_W]);
        p_r <= eneg_r ? -$signed(P_W'(prod_kp_r[PKP_W-1:GAIN_W]))
                      :  $signed(P_W'(prod_kp_r[PKP_W-1:GAIN_W]));
      end
      S_TORQ: begin
        u_r <= u_nxt;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lim         = (int'(joint_r) < LARGE_JOINTS) ? tlim_large_r : tlim_small_r;
    lim_s       = $signed(U_W'(lim));
    torque_sel  = u_r;
    clamped_nxt = 1'b0;
    if (u_r > lim_s) begin
      torque_sel  = lim_s;
      clamped_nxt = 1'b1;
    end else if (u_r < -lim_s) begin
      torque_sel  = -lim_s;
      clamped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_joint_r   <= joint_r;
      out_torque_r  <= torque_sel[TORQUE_W-1:0];
      out_clamped_r <= clamped_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_joint_out = out_joint_r;
  assign out_torque    = $signed(out_torque_r);
  assign out_clamped   = out_clamped_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import jptl_pkg::*;

  localparam int     NUM_JOINTS   = NUM_JOINTS_DEF;
  localparam int     LARGE_JOINTS = LARGE_JOINTS_DEF;
  localparam longint INTEG_MAX    = (longint'(1) <<< 47) - 1;
  localparam longint INTEG_MIN    = -(longint'(1) <<< 47);
  localparam int     REPORT_LIMIT = 10;
  localparam int     LATENCY      = 8;
  localparam int     PHASE_WORDS  = 155;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint;
    logic signed [ANGLE_W-1:0] position;
    logic signed [ANGLE_W-1:0] target;
    logic [GAIN_W-1:0]         stiffness_gain;
    logic [GAIN_W-1:0]         integral_gain;
  } joint_sample_t;

  typedef struct packed {
    logic [JOINT_W-1:0]         joint;
    logic signed [TORQUE_W-1:0] torque;
    logic                       clamped;
  } torque_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [JOINT_W-1:0]         in_joint = '0;
  logic signed [ANGLE_W-1:0]  in_position = '0;
  logic signed [ANGLE_W-1:0]  in_target = '0;
  logic [GAIN_W-1:0]          in_stiffness_gain = '0;
  logic [GAIN_W-1:0]          in_integral_gain = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [JOINT_W-1:0]         out_joint_out;
  logic signed [TORQUE_W-1:0] out_torque;
  logic                       out_clamped;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_TIME_STEP;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  logic [TS_W-1:0]   time_step_q;
  logic [ELIM_W-1:0] error_limit_q;
  logic [TLIM_W-1:0] torque_limit_large_q;
  logic [TLIM_W-1:0] torque_limit_small_q;
  longint            joint_integral[NUM_JOINTS];

  torque_word_t torque_due[$];
  int           fail_count = 0;
  bit           tx_idle = 1'b0;
  bit           rx_idle = 1'b0;
  bit           rx_hold = 1'b0;
  int           stall_left = 0;

  joint_pi_torque_loop i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_joint          (in_joint),
    .in_position       (in_position),
    .in_target         (in_target),
    .in_stiffness_gain (in_stiffness_gain),
    .in_integral_gain  (in_integral_gain),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_joint_out     (out_joint_out),
    .out_torque        (out_torque),
    .out_clamped       (out_clamped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // (a * b) / 2^sh, truncated toward zero
  function automatic longint scale_toward_zero(longint a, longint unsigned b, int sh);
    logic [127:0] mag;
    mag = (a < 0) ? 128'(-a) : 128'(a);
    mag = (mag * 128'(b)) >> sh;
    return (a < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic torque_word_t predict_torque(joint_sample_t s);
    longint       err;
    longint       lim_e;
    longint       integ;
    longint       u;
    longint       lim_t;
    torque_word_t w;
    w.joint   = s.joint;
    w.torque  = '0;
    w.clamped = 1'b0;
    if (s.joint >= NUM_JOINTS) return w;
    lim_e = longint'(error_limit_q);
    err = longint'($signed(s.target)) - longint'($signed(s.position));
    if (err > lim_e) err = lim_e;
    else if (err < -lim_e) err = -lim_e;
    integ = joint_integral[s.joint] + scale_toward_zero(err, 64'(time_step_q), 24);
    if (integ > INTEG_MAX) integ = INTEG_MAX;
    else if (integ < INTEG_MIN) integ = INTEG_MIN;
    joint_integral[s.joint] = integ;
    u = scale_toward_zero(err, 64'(s.stiffness_gain), 20) +
        scale_toward_zero(integ, 64'(s.integral_gain), 20);
    lim_t = (s.joint < LARGE_JOINTS) ? longint'(torque_limit_large_q)
                                     : longint'(torque_limit_small_q);
    if (u > lim_t) begin
      u = lim_t;
      w.clamped = 1'b1;
    end else if (u < -lim_t) begin
      u = -lim_t;
      w.clamped = 1'b1;
    end
    w.torque = u[TORQUE_W-1:0];
    return w;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_TIME_STEP:          time_step_q = value[TS_W-1:0];
      REG_ERROR_LIMIT:        error_limit_q = value[ELIM_W-1:0];
      REG_TORQUE_LIMIT_LARGE: torque_limit_large_q = value[TLIM_W-1:0];
      REG_TORQUE_LIMIT_SMALL: torque_limit_small_q = value[TLIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic joint_sample_t make_sample(int j, logic [ANGLE_W-1:0] pos,
                                                logic [ANGLE_W-1:0] tgt,
                                                logic [GAIN_W-1:0] kp,
                                                logic [GAIN_W-1:0] ki);
    joint_sample_t s;
    s.joint          = JOINT_W'(j);
    s.position       = pos;
    s.target         = tgt;
    s.stiffness_gain = kp;
    s.integral_gain  = ki;
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return GAIN_W'($urandom >> $urandom_range(12, 31));
  endfunction

  function automatic joint_sample_t random_sample();
    joint_sample_t             s;
    logic signed [ANGLE_W-1:0] delta;
    if ($urandom_range(0, 15) == 0) begin
      s.joint = JOINT_W'(NUM_JOINTS);
    end else begin
      s.joint = JOINT_W'($urandom_range(0, NUM_JOINTS - 1));
    end
    s.position = $urandom;
    delta = $signed($urandom) >>> $urandom_range(0, 31);
    s.target = ($urandom_range(0, 4) == 0) ? $urandom : s.position + delta;
    s.stiffness_gain = random_gain();
    s.integral_gain  = random_gain();
    return s;
  endfunction

  task automatic send_word(joint_sample_t s);
    int gap;
    gap = tx_idle ? idle_length() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_joint          <= s.joint;
    in_position       <= s.position;
    in_target         <= s.target;
    in_stiffness_gain <= s.stiffness_gain;
    in_integral_gain  <= s.integral_gain;
    do @(posedge clk); while (in_stall);
    torque_due.push_back(predict_torque(s));
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (torque_due.size() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] ts, logic [CFG_DATA_W-1:0] el,
                           logic [CFG_DATA_W-1:0] tl_large,
                           logic [CFG_DATA_W-1:0] tl_small);
    settle_block();
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_ERROR_LIMIT, el);
    write_reg(REG_TORQUE_LIMIT_LARGE, tl_large);
    write_reg(REG_TORQUE_LIMIT_SMALL, tl_small);
  endtask

  task automatic set_idling(bit tx, bit rx);
    @(posedge clk);
    tx_idle = tx;
    rx_idle = rx;
  endtask

  task automatic test_directed_extremes();
    set_idling(1'b1, 1'b1);
    send_word(make_sample(0, 32'h0, 32'h0, '0, '0));
    send_word(make_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1));
    send_word(make_sample(1, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1));
    send_word(make_sample(3, 32'h0000_1000, 32'h0010_1000, 20'd256, 20'd256));
    send_word(make_sample(4, 32'hFFF0_0000, 32'hFFF0_0000 + ELIM_RST, '1, 20'd1));
    send_word(make_sample(5, 32'h1234_5678, 32'h1230_0000, 20'h0_8000, 20'h0_0400));
    send_word(make_sample(6, 32'h0000_0000, 32'hFFFF_F000, 20'hA_BCDE, 20'h5_4321));
    send_word(make_sample(NUM_JOINTS, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1));
    send_word(make_sample(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1));
  endtask

  task automatic test_error_limit_zero();
    configure(CFG_DATA_W'(TS_RST), '0, CFG_DATA_W'(TLIM_LARGE_RST),
              CFG_DATA_W'(TLIM_SMALL_RST));
    send_word(make_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1));
    send_word(make_sample(1, 32'h0100_0000, 32'hFF00_0000, '1, 20'h0_1000));
    send_word(make_sample(4, 32'h0, 32'h0, 20'd0, '1));
  endtask

  task automatic test_torque_limit_zero();
    configure(CFG_DATA_W'(TS_RST), CFG_DATA_W'(ELIM_RST), '0, '0);
    send_word(make_sample(2, 32'h0, 32'h0004_0000, 20'h0_0100, 20'h0_0100));
    send_word(make_sample(5, 32'h0, 32'h0004_0000, '0, '0));
    send_word(make_sample(6, 32'h0004_0000, 32'h0, 20'h0_0100, '0));
  endtask

  task automatic test_register_extremes();
    configure(CFG_DATA_W'({TS_W{1'b1}}), CFG_DATA_W'({ELIM_W{1'b1}}),
              CFG_DATA_W'({TLIM_W{1'b1}}), CFG_DATA_W'({TLIM_W{1'b1}}));
    send_word(make_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, '1, 20'd1));
    send_word(make_sample(4, 32'h7FFF_FFFF, 32'h8000_0000, '1, 20'd1));
    send_word(make_sample(2, 32'h0000_0010, 32'h0000_0011, 20'd1, 20'd1));
    configure('0, CFG_DATA_W'({ELIM_W{1'b1}}), CFG_DATA_W'(TLIM_LARGE_RST),
              CFG_DATA_W'(TLIM_SMALL_RST));
    send_word(make_sample(3, 32'h0, 32'h0800_0000, 20'h0_0100, '1));
    configure(CFG_DATA_W'(TS_RST), CFG_DATA_W'(ELIM_RST), CFG_DATA_W'(TLIM_LARGE_RST),
              CFG_DATA_W'(TLIM_SMALL_RST));
  endtask

  task automatic test_backpressure();
    set_idling(1'b0, 1'b1);
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      repeat (40) send_word(random_sample());
    join
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: configure(CFG_DATA_W'(TS_RST), CFG_DATA_W'(ELIM_RST),
                     CFG_DATA_W'(TLIM_LARGE_RST), CFG_DATA_W'(TLIM_SMALL_RST));
        1, 4: configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                        CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        2: configure('1, '1, '1, '1);
        default: configure(CFG_DATA_W'($urandom_range(0, 255)),
                           CFG_DATA_W'($urandom_range(0, 65535)),
                           CFG_DATA_W'($urandom_range(0, 1 << 18)),
                           CFG_DATA_W'($urandom_range(0, 1 << 18)));
      endcase
      set_idling(p % 3 != 2, p % 4 != 3);
      repeat (PHASE_WORDS) send_word(random_sample());
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (!rx_idle) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
        stall_left = idle_length();
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin : check_torque
    torque_word_t got;
    torque_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_joint_out, out_torque, out_clamped};
      if (torque_due.size() == 0) begin
        note_failure($sformatf("unexpected word: joint %0d torque %0d clamped %0b",
                               got.joint, $signed(got.torque), got.clamped));
      end else begin
        want = torque_due.pop_front();
        if (got.joint !== want.joint || got.torque !== want.torque ||
            got.clamped !== want.clamped) begin
          note_failure($sformatf(
            "expected joint %0d torque %0d clamped %0b, got joint %0d torque %0d clamped %0b",
            want.joint, $signed(want.torque), want.clamped,
            got.joint, $signed(got.torque), got.clamped));
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("** joint_pi_torque_loop: FAILED **");
    $finish;
  end

  initial begin
    time_step_q          = TS_RST;
    error_limit_q        = ELIM_RST;
    torque_limit_large_q = TLIM_LARGE_RST;
    torque_limit_small_q = TLIM_SMALL_RST;
    foreach (joint_integral[j]) joint_integral[j] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_error_limit_zero();
    test_torque_limit_zero();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    settle_block();
    repeat (LATENCY * 3) @(posedge clk);
    if (torque_due.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", torque_due.size()));
    end
    if (fail_count == 0) begin
      $display("** joint_pi_torque_loop: PASSED **");
    end else begin
      $display("** joint_pi_torque_loop: FAILED **");
    end
    $finish;
  end

endmodule
